// ----- rtl/core/mwlfo_pkg.sv -----
// ----------------------------------------------------------------------------
// mwlfo_pkg
// Shared types and constants of the multi-waveform control-rate oscillator.
// ----------------------------------------------------------------------------
package mwlfo_pkg;

  localparam int unsigned ValW     = 24;
  localparam int unsigned StepW    = 21;
  localparam int unsigned SelW     = 3;
  localparam int unsigned SeedW    = 32;
  localparam int unsigned LenW     = 5;
  localparam int unsigned CfgAddrW = 2;
  localparam int unsigned CfgDataW = 32;
  localparam logic [SeedW-1:0] LfsrTaps = 32'hA300_0000;

  localparam logic [CfgAddrW-1:0] RegTriStep    = 2'd0;
  localparam logic [CfgAddrW-1:0] RegWaveSelect = 2'd1;
  localparam logic [CfgAddrW-1:0] RegNoiseSeed  = 2'd2;

  typedef enum logic [SelW-1:0] {
    WaveSine    = 3'd0,
    WaveTri     = 3'd1,
    WaveSawUp   = 3'd2,
    WaveSawDown = 3'd3,
    WaveSquare  = 3'd4,
    WaveHold    = 3'd5,
    WaveOffA    = 3'd6,
    WaveOffB    = 3'd7
  } wave_e;

  typedef enum logic [1:0] {
    BkIdle,
    BkDiv,
    BkEmit
  } bk_state_e;

  // one chunk request as handed from the front to the back
  typedef struct packed {
    logic            level;
    logic [LenW-1:0] len;
  } chunk_t;

  function automatic logic signed [ValW-1:0] sat_val(input logic signed [63:0] v);
    logic signed [63:0] hi;
    logic signed [63:0] lo;
    hi = 64'sd8388607;
    lo = -64'sd8388608;
    if (v > hi) return ValW'(hi);
    if (v < lo) return ValW'(lo);
    return ValW'(v);
  endfunction

endpackage

// ----- rtl/core/mwlfo_if.sv -----
// ----------------------------------------------------------------------------
// mwlfo_in_if / mwlfo_out_if
// Valid/ready channels carrying chunk requests and output samples.
// ----------------------------------------------------------------------------
interface mwlfo_in_if;
  logic       valid;
  logic       ready;
  logic       trigger_level;
  logic [4:0] chunk_length;
  modport source (output valid, trigger_level, chunk_length, input ready);
  modport sink (input valid, trigger_level, chunk_length, output ready);
endinterface

interface mwlfo_out_if;
  logic               valid;
  logic               ready;
  logic signed [23:0] sample;
  logic               last;
  modport source (output valid, sample, last, input ready);
  modport sink (input valid, sample, last, output ready);
endinterface

// ----- rtl/core/mwlfo_front.sv -----
// ----------------------------------------------------------------------------
// mwlfo_front
// Accepts chunk requests, drops empty ones, clamps length, queues the rest.
// ----------------------------------------------------------------------------
module mwlfo_front
  import mwlfo_pkg::*;
#(
  parameter int unsigned MaxChunk = 24
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  mwlfo_in_if.sink   in_if,
  output logic       q_valid_o,
  output chunk_t     q_data_o,
  input  logic       q_pop_i
);

  chunk_t     buf_q [2];
  logic [1:0] cnt_q, cnt_d;
  logic       wr_q, wr_d, rd_q, rd_d;
  logic       push;
  chunk_t     cin;

  assign in_if.ready = (cnt_q != 2'd2);
  assign push = in_if.valid && in_if.ready && (in_if.chunk_length != '0);
  assign q_valid_o = (cnt_q != 2'd0);
  assign q_data_o  = buf_q[rd_q];

  always_comb begin
    cin.level = in_if.trigger_level;
    cin.len   = (32'(in_if.chunk_length) > MaxChunk) ? LenW'(MaxChunk) : in_if.chunk_length;
    cnt_d = cnt_q + {1'b0, push} - {1'b0, q_pop_i};
    wr_d  = wr_q ^ push;
    rd_d  = rd_q ^ q_pop_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
    end else begin
      cnt_q <= cnt_d;
      wr_q  <= wr_d;
      rd_q  <= rd_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) buf_q[wr_q] <= cin;
  end

endmodule

// ----- rtl/core/mwlfo_back.sv -----
// ----------------------------------------------------------------------------
// mwlfo_back
// Oscillator state update, per-chunk slope division and sample emission.
// ----------------------------------------------------------------------------
module mwlfo_back
  import mwlfo_pkg::*;
#(
  parameter int unsigned FracBits = 20
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CfgAddrW-1:0]   cfg_addr_i,
  input  logic [CfgDataW-1:0]   cfg_data_i,
  input  logic                  q_valid_i,
  input  chunk_t                q_data_i,
  output logic                  q_pop_o,
  mwlfo_out_if.source           out_if
);

  localparam logic signed [63:0] One = 64'sd1 <<< FracBits;
  localparam int unsigned DivW = ValW + 2;

  logic [StepW-1:0] step_q;
  logic [SelW-1:0]  sel_q;
  logic [SeedW-1:0] lfsr_q, lfsr_d;

  logic held_q;
  logic [1:0] quad_q;
  logic signed [ValW-1:0] phase_q, dir_q, sine_q, saw_q, sq_q, hold_q;
  logic signed [ValW-1:0] prev_q, tgt_q;
  // saw slope starts from zero after reset although its target starts at minus one
  logic saw_fresh_q;

  bk_state_e st_q, st_d;
  logic [LenW-1:0] k_q, j_q, dcnt_q;
  // restoring divider of |target - prev| by k
  logic [DivW-1:0] rem_q, quo_q;
  logic            neg_q;
  logic signed [ValW+1:0] acc_q;
  logic signed [DivW-1:0] delta_q;

  // state update (combinational, evaluated when a request is popped)
  logic n_held;
  logic [1:0] n_quad;
  logic signed [63:0] n_phase, n_dir, n_sine, n_saw, n_sq, n_hold, st64;
  logic signed [63:0] other, prod, sel_tgt, sel_prev, diff;
  logic [SeedW-1:0] lf;
  logic draw;

  // all interpolation channels are linear, so only the selected one is tracked;
  // prev of the selected channel equals its last target
  logic signed [ValW-1:0] sel_prev_now;
  always_comb begin
    unique case (wave_e'(sel_q))
      WaveSine:               sel_prev_now = sine_q;
      WaveTri:                sel_prev_now = phase_q;
      WaveSawUp, WaveSawDown: sel_prev_now = saw_fresh_q ? '0 : saw_q;
      WaveSquare:             sel_prev_now = sq_q;
      WaveHold:               sel_prev_now = hold_q;
      default:                sel_prev_now = '0;
    endcase
  end

  always_comb begin
    st64 = 64'(step_q);
    n_held = held_q; n_quad = quad_q;
    n_phase = 64'(phase_q); n_dir = 64'(dir_q); n_sine = 64'(sine_q);
    n_saw = 64'(saw_q); n_sq = 64'(sq_q); n_hold = 64'(hold_q);
    draw = 1'b0;
    if (!held_q && q_data_i.level) begin
      n_held = 1'b1; n_phase = 0; n_quad = 2'd0;
      n_dir = 64'(sat_val(st64)); n_sq = 64'(sat_val(-One)); n_sine = 0;
    end
    if (n_held && !q_data_i.level) n_held = 1'b0;
    priority if (n_phase >= One) begin
      n_quad = 2'd1; n_dir = 64'(sat_val(-st64));
    end else if (n_phase <= -One) begin
      n_quad = 2'd3; n_dir = 64'(sat_val(st64));
    end else if (n_quad == 2'd1 && n_phase < 0) begin
      n_quad = 2'd2; n_sq = 64'(sat_val(One)); draw = 1'b1;
    end else if (n_quad == 2'd3 && n_phase > 0) begin
      n_quad = 2'd0; n_sq = 64'(sat_val(-One)); draw = 1'b1;
      n_saw = 64'(sat_val(-One));
    end
    lf = lfsr_q;
    for (int i = 0; i < 32; i++) lf = lf[0] ? ((lf >> 1) ^ LfsrTaps) : (lf >> 1);
    if (draw) n_hold = 64'(sat_val(64'(lf >> (31 - FracBits)) - One));
    lfsr_d = draw ? lf : lfsr_q;
    other = (n_quad < 2'd2) ? (2 * One - n_phase) : (2 * One + n_phase);
    prod = n_phase * other + (64'sd1 <<< (FracBits - 1));
    n_sine = 64'(sat_val(prod >>> FracBits));
    n_saw = 64'(sat_val(n_saw + (st64 >>> 1)));
    n_phase = 64'(sat_val(n_phase + n_dir));
    unique case (wave_e'(sel_q))
      WaveSine:               sel_tgt = n_sine;
      WaveTri:                sel_tgt = n_phase;
      WaveSawUp, WaveSawDown: sel_tgt = n_saw;
      WaveSquare:             sel_tgt = n_sq;
      WaveHold:               sel_tgt = n_hold;
      default:                sel_tgt = 0;
    endcase
    sel_prev = 64'(sel_prev_now);
    diff = sel_tgt - sel_prev;
  end

  logic pop;
  assign pop = (st_q == BkIdle) && q_valid_i;
  assign q_pop_o = pop;

  always_comb begin
    st_d = st_q;
    unique case (st_q)
      BkIdle: if (q_valid_i) st_d = BkDiv;
      BkDiv:  if (dcnt_q == '0) st_d = BkEmit;
      BkEmit: if (out_if.ready && j_q == k_q) st_d = BkIdle;
      default: st_d = BkIdle;
    endcase
  end

  logic [DivW-1:0] trial;
  logic signed [63:0] cur, outv;
  always_comb begin
    trial = {rem_q[DivW-2:0], quo_q[DivW-1]} - DivW'(k_q);
    cur = (j_q == k_q) ? 64'(tgt_q) : 64'(acc_q);
    unique case (wave_e'(sel_q))
      WaveSawDown, WaveSquare: outv = 64'(sat_val(-cur));
      WaveOffA, WaveOffB:      outv = 0;
      default:                 outv = cur;
    endcase
    out_if.valid  = (st_q == BkEmit);
    out_if.sample = ValW'(outv);
    out_if.last   = (j_q == k_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= StepW'(65536); sel_q <= '0; lfsr_q <= 32'd1;
      held_q <= 1'b0; quad_q <= '0; phase_q <= '0; dir_q <= ValW'(65536);
      sine_q <= '0; saw_q <= ValW'(sat_val(-One)); sq_q <= '0; hold_q <= '0;
      st_q <= BkIdle; prev_q <= '0; saw_fresh_q <= 1'b1;
    end else begin
      st_q <= st_d;
      if (cfg_we_i) begin
        unique case (cfg_addr_i)
          RegTriStep:    step_q <= cfg_data_i[StepW-1:0];
          RegWaveSelect: sel_q <= cfg_data_i[SelW-1:0];
          RegNoiseSeed:  lfsr_q <= (cfg_data_i == '0) ? 32'd1 : cfg_data_i;
          default: ;
        endcase
      end
      if (pop) begin
        held_q <= n_held; quad_q <= n_quad; lfsr_q <= lfsr_d;
        phase_q <= ValW'(n_phase); dir_q <= ValW'(n_dir); sine_q <= ValW'(n_sine);
        saw_q <= ValW'(n_saw); sq_q <= ValW'(n_sq); hold_q <= ValW'(n_hold);
        prev_q <= sel_prev_now;
        saw_fresh_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop) begin
      k_q <= q_data_i.len; j_q <= LenW'(1);
      tgt_q <= ValW'(sel_tgt);
      neg_q <= diff < 0;
      quo_q <= DivW'((diff < 0) ? -diff : diff);
      rem_q <= '0; dcnt_q <= LenW'(DivW - 1);
    end else if (st_q == BkDiv) begin
      quo_q <= {quo_q[DivW-2:0], ~trial[DivW-1]};
      rem_q <= trial[DivW-1] ? {rem_q[DivW-2:0], quo_q[DivW-1]} : trial;
      if (dcnt_q != '0) dcnt_q <= dcnt_q - LenW'(1);
      else begin
        delta_q <= neg_q ? -$signed({quo_q[DivW-2:0], ~trial[DivW-1]})
                         : $signed({quo_q[DivW-2:0], ~trial[DivW-1]});
        acc_q <= (ValW+2)'(prev_q) + (neg_q
                 ? -$signed({quo_q[DivW-2:0], ~trial[DivW-1]})
                 : $signed({quo_q[DivW-2:0], ~trial[DivW-1]}));
      end
    end else if (st_q == BkEmit && out_if.ready) begin
      j_q <= j_q + LenW'(1);
      acc_q <= acc_q + (ValW+2)'(delta_q);
    end
  end

endmodule

// ----- rtl/core/multi_waveform_lfo.sv -----
// ----------------------------------------------------------------------------
// multi_waveform_lfo
// Control-rate LFO: sine, triangle, saws, square and sample-and-hold.
// ----------------------------------------------------------------------------
// Each chunk request updates the oscillator once, then a serial divider forms
// the per-sample slope, then chunk_length samples leave at one per cycle while
// the output is ready.
// A two-entry queue lets new requests be taken while a chunk is emitted.
module multi_waveform_lfo
  import mwlfo_pkg::*;
#(
  parameter int unsigned MaxChunk = 24,
  parameter int unsigned FracBits = 20
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgAddrW-1:0] cfg_addr_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  mwlfo_in_if.sink            in_if,
  mwlfo_out_if.source         out_if
);

  logic   q_valid, q_pop;
  chunk_t q_data;

  mwlfo_front #(.MaxChunk(MaxChunk)) u_front (
    .clk_i, .rst_ni, .in_if,
    .q_valid_o(q_valid), .q_data_o(q_data), .q_pop_i(q_pop)
  );

  mwlfo_back #(.FracBits(FracBits)) u_back (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_addr_i, .cfg_data_i,
    .q_valid_i(q_valid), .q_data_i(q_data), .q_pop_o(q_pop), .out_if
  );

endmodule

// ----- tb/sv/tb_multi_waveform_lfo.sv -----
// ----------------------------------------------------------------------------
// tb_multi_waveform_lfo
// Self-checking bench for the multi-waveform LFO: random chunk requests with
// random gaps and output stalls, register changes between drained phases, and
// every output sample compared against an in-bench model of the oscillator.
// ----------------------------------------------------------------------------
module tb_multi_waveform_lfo;
  import mwlfo_pkg::*;

  localparam int unsigned MaxLen  = 24;
  localparam longint      OneFx   = 64'sd1 << 20;
  localparam int unsigned Settle  = 80;
  localparam int unsigned RunCap  = 800000;

  logic                clk;
  logic                rst_n;
  logic                cfg_we;
  logic [CfgAddrW-1:0] cfg_addr;
  logic [CfgDataW-1:0] cfg_data;

  mwlfo_in_if  req_ch ();
  mwlfo_out_if smp_ch ();

  multi_waveform_lfo dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .cfg_we_i   (cfg_we),
    .cfg_addr_i (cfg_addr),
    .cfg_data_i (cfg_data),
    .in_if      (req_ch),
    .out_if     (smp_ch)
  );

  typedef struct {
    logic signed [ValW-1:0] sample;
    logic                   last;
  } lfo_sample_t;

  class lfo_scoreboard;
    lfo_sample_t            samples_due[$];
    int unsigned            errors;
    // register copies
    longint                 tri_step;
    wave_e                  wave_sel;
    logic [SeedW-1:0]       seed;
    // oscillator state
    bit                     trig_held;
    int unsigned            quad;
    longint                 phase;
    longint                 dir_step;
    longint                 sine_tgt;
    longint                 saw_tgt;
    longint                 sq_tgt;
    longint                 hold_tgt;
    longint                 prev_val[5];
    logic [SeedW-1:0]       lfsr;

    function new();
      errors   = 0;
      tri_step = 65536;
      wave_sel = WaveSine;
      seed     = 1;
      trig_held = 0;
      quad     = 0;
      phase    = 0;
      dir_step = tri_step;
      sine_tgt = 0;
      saw_tgt  = -OneFx;
      sq_tgt   = 0;
      hold_tgt = 0;
      foreach (prev_val[i]) prev_val[i] = 0;
      lfsr     = seed;
    endfunction

    function longint clip24(longint v);
      if (v > 64'sd8388607) return 64'sd8388607;
      if (v < -64'sd8388608) return -64'sd8388608;
      return v;
    endfunction

    function void set_reg(logic [CfgAddrW-1:0] idx, logic [CfgDataW-1:0] val);
      if (idx == RegTriStep) begin
        tri_step = longint'(val & 32'h1F_FFFF);
      end else if (idx == RegWaveSelect) begin
        wave_sel = wave_e'(val[SelW-1:0]);
      end else if (idx == RegNoiseSeed) begin
        seed = (val == 0) ? 32'd1 : val;
        lfsr = seed;
      end
    endfunction

    function longint next_hold();
      bit lsb;
      for (int n = 0; n < 32; n++) begin
        lsb  = lfsr[0];
        lfsr = lfsr >> 1;
        if (lsb) lfsr = lfsr ^ LfsrTaps;
      end
      return clip24(longint'(lfsr >> 11) - OneFx);
    endfunction

    // oscillator update once per chunk, then the interpolated samples
    function void note_chunk(logic lvl, logic [LenW-1:0] len);
      longint      k;
      longint      tg[5];
      longint      dl[5];
      longint      v[5];
      longint      s;
      longint      other;
      longint      prod;
      lfo_sample_t e;
      k = len;
      if (k == 0) return;
      if (k > MaxLen) k = MaxLen;
      if (!trig_held && lvl) begin
        trig_held = 1;
        phase     = 0;
        quad      = 0;
        dir_step  = clip24(tri_step);
        sq_tgt    = -OneFx;
        sine_tgt  = 0;
      end
      if (trig_held && !lvl) trig_held = 0;
      if (phase >= OneFx) begin
        quad     = 1;
        dir_step = clip24(-tri_step);
      end else if (phase <= -OneFx) begin
        quad     = 3;
        dir_step = clip24(tri_step);
      end else if (quad == 1 && phase < 0) begin
        quad     = 2;
        sq_tgt   = OneFx;
        hold_tgt = next_hold();
      end else if (quad == 3 && phase > 0) begin
        quad     = 0;
        sq_tgt   = -OneFx;
        hold_tgt = next_hold();
        saw_tgt  = -OneFx;
      end
      other    = (quad < 2) ? (2 * OneFx - phase) : (2 * OneFx + phase);
      prod     = phase * other + (64'sd1 << 19);
      sine_tgt = clip24(prod >>> 20);
      saw_tgt  = clip24(saw_tgt + (tri_step >>> 1));
      phase    = clip24(phase + dir_step);
      tg[0] = sine_tgt;
      tg[1] = saw_tgt;
      tg[2] = hold_tgt;
      tg[3] = phase;
      tg[4] = sq_tgt;
      for (int i = 0; i < 5; i++) dl[i] = (tg[i] - prev_val[i]) / k;
      for (longint j = 1; j <= k; j++) begin
        for (int i = 0; i < 5; i++) v[i] = (j == k) ? tg[i] : prev_val[i] + j * dl[i];
        case (wave_sel)
          WaveSine:    s = v[0];
          WaveTri:     s = v[3];
          WaveSawUp:   s = v[1];
          WaveSawDown: s = clip24(-v[1]);
          WaveSquare:  s = clip24(-v[4]);
          WaveHold:    s = v[2];
          default:     s = 0;
        endcase
        e.sample = s[ValW-1:0];
        e.last   = (j == k);
        samples_due.push_back(e);
      end
      for (int i = 0; i < 5; i++) prev_val[i] = tg[i];
    endfunction

    function void report(string what);
      errors++;
      $display("MISMATCH @%0t: %s", $time, what);
    endfunction

    function void check_sample(logic signed [ValW-1:0] smp, logic lst);
      lfo_sample_t e;
      if (samples_due.size() == 0) begin
        report($sformatf("unexpected sample %0d last %0b", smp, lst));
        return;
      end
      e = samples_due.pop_front();
      if (smp !== e.sample)
        report($sformatf("sample got %0d want %0d", smp, e.sample));
      if (lst !== e.last)
        report($sformatf("last got %0b want %0b", lst, e.last));
    endfunction
  endclass

  lfo_scoreboard sb;
  bit            rx_calm;
  bit            rx_hold_req;
  int unsigned   cycles;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > RunCap) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // sample receiver with random stalls and one long hold-off
  initial begin
    int unsigned stall;
    smp_ch.ready <= 1'b0;
    @(posedge rst_n);
    forever begin
      stall = rx_calm ? 0 : $urandom_range(0, 13);
      if (rx_hold_req) begin
        stall       = 400;
        rx_hold_req = 0;
      end
      if (stall > 0) begin
        smp_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      smp_ch.ready <= 1'b1;
      do @(posedge clk); while (!smp_ch.valid);
      sb.check_sample(smp_ch.sample, smp_ch.last);
    end
  end

  task automatic write_reg(logic [CfgAddrW-1:0] idx, logic [CfgDataW-1:0] val);
    cfg_we   <= 1'b1;
    cfg_addr <= idx;
    cfg_data <= val;
    @(posedge clk);
    sb.set_reg(idx, val);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic send_chunk(logic lvl, logic [LenW-1:0] len, bit no_gap = 0);
    int unsigned gap;
    gap = no_gap ? 0 : $urandom_range(0, 13);
    if (gap > 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_ch.valid         <= 1'b1;
    req_ch.trigger_level <= lvl;
    req_ch.chunk_length  <= len;
    do @(posedge clk); while (!req_ch.ready);
    sb.note_chunk(lvl, len);
  endtask

  task automatic drain();
    req_ch.valid <= 1'b0;
    while (sb.samples_due.size() != 0) @(posedge clk);
    repeat (Settle) @(posedge clk);
  endtask

  // mostly legal lengths, some zero and overlong requests
  function automatic logic [LenW-1:0] pick_len();
    int unsigned r;
    r = $urandom_range(0, 19);
    if (r == 0) return '0;
    if (r == 1) return LenW'($urandom_range(25, 31));
    if (r < 6) return LenW'($urandom_range(1, 4));
    return LenW'($urandom_range(1, 24));
  endfunction

  initial begin
    logic        lvl;
    logic [31:0] step_pick[4];
    sb = new();
    cycles       = 0;
    rx_calm      = 0;
    rx_hold_req  = 0;
    rst_n        = 1'b0;
    cfg_we       <= 1'b0;
    cfg_addr     <= '0;
    cfg_data     <= '0;
    req_ch.valid <= 1'b0;
    req_ch.trigger_level <= 1'b0;
    req_ch.chunk_length  <= '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: length extremes, zero and overlong, trigger edges
    send_chunk(1'b0, 5'd1);
    send_chunk(1'b0, 5'd24);
    send_chunk(1'b1, 5'd16);
    send_chunk(1'b1, 5'd25);
    send_chunk(1'b0, 5'd31);
    send_chunk(1'b0, 5'd0);
    send_chunk(1'b1, 5'd2);
    send_chunk(1'b0, 5'd0);
    send_chunk(1'b0, 5'd3);
    drain();
    write_reg(RegTriStep, 32'h1F_FFFF);
    write_reg(RegWaveSelect, 32'(WaveTri));
    write_reg(RegNoiseSeed, 32'd0);
    for (int n = 0; n < 6; n++) send_chunk(n[0], 5'd24, 1);
    drain();
    write_reg(RegTriStep, 32'd0);
    write_reg(RegWaveSelect, 32'(WaveHold));
    write_reg(RegNoiseSeed, 32'hFFFF_FFFF);
    for (int n = 0; n < 6; n++) send_chunk(1'b0, LenW'(n + 1));
    drain();

    // random phases: one per waveform select, steps at the extremes too
    step_pick[0] = 32'd1048576;
    step_pick[1] = 32'd0;
    step_pick[2] = 32'h1F_FFFF;
    lvl = 1'b0;
    for (int ph = 0; ph < 8; ph++) begin
      step_pick[3] = $urandom_range(60000, 700000);
      write_reg(RegWaveSelect, 32'(ph));
      write_reg(RegTriStep, (ph % 3 == 0) ? step_pick[ph / 3] : step_pick[3]);
      write_reg(RegNoiseSeed, $urandom());
      rx_calm = (ph == 5);
      if (ph == 3) rx_hold_req = 1;
      for (int n = 0; n < 22; n++) begin
        if ($urandom_range(0, 15) == 0) lvl = ~lvl;
        send_chunk(lvl, pick_len(), ph == 6);
      end
      drain();
    end

    if (sb.errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/core/mwlfo_pkg.sv
rtl/core/mwlfo_if.sv
rtl/core/mwlfo_front.sv
rtl/core/mwlfo_back.sv
rtl/core/multi_waveform_lfo.sv
tb/sv/tb_multi_waveform_lfo.sv
